FILE: src/assert_macros.svh
// assertion macros shared by the id registry rtl
// needs clk and rst_n in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define IKHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define IKHT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/ikht_pkg.sv
// shared types and constants for the id keyed handle table
// no dependencies
package ikht_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int ID_W       = 32;
    localparam int PL_W       = 32;
    localparam int MODE_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int CAP_W      = 5;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = ID_W + PL_W;

    localparam logic [ID_W-1:0]  ID_ALL_ONES   = '1;
    localparam logic [ID_W-1:0]  ID_ONE        = ID_W'(1);
    localparam logic [ID_W-1:0]  BASE_ID_RESET = ID_W'(1);
    localparam logic [CAP_W-1:0] CAP_RESET     = CAP_W'(16);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

    // mode field codes
    localparam logic [MODE_W-1:0] MODE_ADD_AUTO = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_ID   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET_ID   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GET_IDX  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD_AUTO,
        OP_ADD_ID,
        OP_GET_ID,
        OP_GET_IDX,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t               op;
        logic              key_bad;
        logic [ID_W-1:0]   key_id;
        logic [PL_W-1:0]   payload;
        logic [SLOT_W-1:0] slot_index;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]  base_id;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

endpackage

FILE: src/ikht_if.sv
// request and response channel interfaces for the id keyed handle table
// depends on ikht_pkg
interface ikht_req_if;
    logic                          valid;
    logic                          ready;
    logic [ikht_pkg::MODE_W-1:0]   mode;
    logic [ikht_pkg::ID_W-1:0]     key_id;
    logic [ikht_pkg::PL_W-1:0]     payload_in;
    logic [ikht_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, mode, key_id, payload_in, slot_index, input ready);
    modport sink   (input valid, mode, key_id, payload_in, slot_index, output ready);
endinterface

interface ikht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ikht_pkg::STATUS_W-1:0] status;
    logic [ikht_pkg::ID_W-1:0]     result_id;
    logic [ikht_pkg::PL_W-1:0]     result_payload;

    modport source (output valid, status, result_id, result_payload, input ready);
    modport sink   (input valid, status, result_id, result_payload, output ready);
endinterface

FILE: src/ikht_ram.sv
// generic single write port ram with registered read
// no dependencies
module ikht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/ikht_front.sv
// front end: accepts request beats, classifies the mode, queues commands
// depends on ikht_pkg, ikht_req_if and assert_macros.svh
`include "assert_macros.svh"

module ikht_front (
    input  logic           clk,
    input  logic           rst_n,
    ikht_req_if.sink       req,
    output ikht_pkg::cmd_t cmd,
    output logic           cmd_valid,
    input  logic           cmd_pop
);
    import ikht_pkg::*;

    localparam int QD = 2;

    cmd_t       slot_reg [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       cls;

    // classify the incoming beat
    always_comb
    begin
        cls.key_id     = req.key_id;
        cls.payload    = req.payload_in;
        cls.slot_index = req.slot_index;
        cls.key_bad    = (req.key_id == '0) || (req.key_id == ID_ALL_ONES);
        unique case (req.mode)
            MODE_ADD_AUTO: cls.op = OP_ADD_AUTO;
            MODE_ADD_ID:   cls.op = OP_ADD_ID;
            MODE_GET_ID:   cls.op = OP_GET_ID;
            MODE_GET_IDX:  cls.op = OP_GET_IDX;
            MODE_CLEAR:    cls.op = OP_CLEAR;
            default:       cls.op = OP_NOP;
        endcase
    end

    // queue handshake
    assign req.ready = (fill_reg != 2'(QD));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    `IKHT_ASSERT(a_fill_bound, fill_reg <= 2'(QD), "command queue overfilled")
    `IKHT_ASSERT(a_pop_nonempty, cmd_pop |-> cmd_valid, "pop from empty command queue")

endmodule

FILE: src/ikht_back.sv
// back end: owns the entry ram, count and id counter, scans and answers
// depends on ikht_pkg, ikht_rsp_if, ikht_ram and assert_macros.svh
`include "assert_macros.svh"

module ikht_back #(
    parameter int DEPTH = ikht_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ikht_pkg::cfg_t cfg,
    input  ikht_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    ikht_rsp_if.source     rsp
);
    import ikht_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic [PL_W-1:0]   pl_reg, pl_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PL_W-1:0]   pl_out_reg, pl_out_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ID_W-1:0]   rd_id;
    logic [PL_W-1:0]   rd_pl;

    logic              out_free;
    logic              full;
    logic              idx_ok;
    logic              issue;
    logic              hit;
    logic [ID_W-1:0]   start_id;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  slot_ext;

    logic              scan_ok;
    logic              fail_clean;
    logic              clear_pop;

    ikht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // decode helpers
    assign rd_id     = ram_rdata[ENTRY_W-1:PL_W];
    assign rd_pl     = ram_rdata[PL_W-1:0];
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign count_ext = CMP_W'(count_reg);
    assign slot_ext  = CMP_W'(cmd.slot_index);
    assign full      = (count_ext >= CMP_W'(cfg.capacity)) || (count_ext >= CMP_W'(DEPTH));
    assign idx_ok    = (slot_ext < count_ext) && (slot_ext < CMP_W'(DEPTH));
    assign start_id  = (cfg.base_id != '0) ? cfg.base_id : ID_ONE;
    assign issue     = (ptr_reg < lim_reg);
    assign hit       = pend_reg && ((op_reg == OP_GET_IDX) || (rd_id == key_reg));

    // response port
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.result_id      = id_reg;
    assign rsp.result_payload = pl_out_reg;

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pl_next        = pl_reg;
        ptr_next       = ptr_reg;
        lim_next       = lim_reg;
        pend_next      = 1'b0;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        id_next        = id_reg;
        pl_out_next    = pl_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = {next_id_reg, cmd.payload};
        cmd_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop  = 1'b1;
                    op_next  = cmd.op;
                    key_next = cmd.key_id;
                    pl_next  = cmd.payload;
                    unique case (cmd.op)
                        OP_ADD_AUTO:
                        begin
                            rsp_valid_next = 1'b1;
                            id_next        = '0;
                            pl_out_next    = '0;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if ((next_id_reg == '0) || (next_id_reg == ID_ALL_ONES))
                            begin
                                status_next = ST_EXHAUSTED;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                next_id_next = next_id_reg + ID_ONE;
                                status_next  = ST_OK;
                                id_next      = next_id_reg;
                                pl_out_next  = cmd.payload;
                            end
                        end
                        OP_ADD_ID, OP_GET_ID:
                        begin
                            if ((cmd.op == OP_ADD_ID) && (full || cmd.key_bad))
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = full ? ST_FULL : ST_INVALID;
                                id_next        = '0;
                                pl_out_next    = '0;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                lim_next   = count_reg;
                                state_next = S_SCAN;
                            end
                        end
                        OP_GET_IDX:
                        begin
                            if (idx_ok)
                            begin
                                ptr_next   = slot_ext[CNT_W-1:0];
                                lim_next   = slot_ext[CNT_W-1:0] + CNT_W'(1);
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = ST_NOT_FOUND;
                                id_next        = '0;
                                pl_out_next    = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            next_id_next   = start_id;
                            rsp_valid_next = 1'b1;
                            status_next    = ST_OK;
                            id_next        = '0;
                            pl_out_next    = '0;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ST_OK;
                            id_next        = '0;
                            pl_out_next    = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, checked the cycle after
                pend_next = issue;
                ptr_next  = issue ? ptr_reg + CNT_W'(1) : ptr_reg;
                if (hit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    if (op_reg == OP_ADD_ID)
                    begin
                        status_next = ST_DUPLICATE;
                        id_next     = '0;
                        pl_out_next = '0;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        id_next     = rd_id;
                        pl_out_next = rd_pl;
                    end
                end
                else if (!issue)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    if (op_reg == OP_ADD_ID)
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = {key_reg, pl_reg};
                        count_next   = count_reg + CNT_W'(1);
                        next_id_next = (key_reg >= next_id_reg) ? key_reg + ID_ONE
                                                                : next_id_reg;
                        status_next  = ST_OK;
                        id_next      = key_reg;
                        pl_out_next  = pl_reg;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        id_next     = '0;
                        pl_out_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            next_id_reg   <= BASE_ID_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pl_reg     <= pl_next;
        ptr_reg    <= ptr_next;
        lim_reg    <= lim_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        pl_out_reg <= pl_out_next;
    end

    // assertion helpers
    assign scan_ok    = (state_reg != S_SCAN) || (ptr_reg <= lim_reg);
    assign fail_clean = !rsp_valid_reg || (status_reg == ST_OK)
                        || ((id_reg == '0) && (pl_out_reg == '0));
    assign clear_pop  = cmd_pop && (cmd.op == OP_CLEAR);

    `IKHT_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count beyond depth")
    `IKHT_ASSERT(a_scan_bound, scan_ok, "scan ran past limit")
    `IKHT_ASSERT(a_fail_zero, fail_clean, "failed beat carries data")
    `IKHT_ASSERT_NEXT(a_clear_empties, clear_pop, count_reg == '0, "clear left entries")

endmodule

FILE: src/id_keyed_handle_table.sv
// Id keyed handle table: up to DEPTH (id, payload) entries filled in insertion order,
// with add by issued id, add by given id, get by id, get by slot and clear. Requests
// go into a two-beat command queue, so the request side keeps flowing while the
// executor works. Add with issued id, clear, failed checks and undefined modes are
// answered without a scan; add with given id and get by id scan the filled slots one
// per cycle through the single read port of the entry ram; get by slot reads one slot.
// One command runs at a time. A new base id takes effect at the next clear.
// depends on ikht_pkg, ikht_if, ikht_front, ikht_back
module id_keyed_handle_table #(
    parameter int DEPTH = ikht_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ikht_req_if.sink                        req,
    ikht_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [ikht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ikht_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ikht_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ID:  cfg_next.base_id  = cfg_data[ID_W-1:0];
                REG_CAPACITY: cfg_next.capacity = cfg_data[CAP_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_id  <= BASE_ID_RESET;
            cfg_reg.capacity <= CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ikht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    ikht_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

FILE: bench/testbench.sv
// self-checking bench for id_keyed_handle_table: directed and random requests
// against a mirror of the table, across several base id and capacity settings
// depends on ikht_pkg, ikht_if and the id_keyed_handle_table rtl
module testbench;
    import ikht_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 162;
    localparam int PHASE_COUNT  = 10;

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] id;
        logic [PL_W-1:0] payload;
    } table_result_t;

    // mirror of the registry: predicts one result per accepted request
    class registry_mirror;
        logic [ID_W-1:0]  ids [TABLE_DEPTH];
        logic [PL_W-1:0]  pls [TABLE_DEPTH];
        int unsigned      count;
        logic [ID_W-1:0]  next_id;
        logic [ID_W-1:0]  base_id;
        logic [CAP_W-1:0] capacity;
        table_result_t    pending_results[$];
        int               errors;
        int               results_checked;
        int               status_seen[6];

        function new();
            count = 0;
            base_id = BASE_ID_RESET;
            capacity = CAP_RESET;
            next_id = start_id();
            errors = 0;
            results_checked = 0;
            foreach (ids[i])
            begin
                ids[i] = '0;
                pls[i] = '0;
            end
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function logic [ID_W-1:0] start_id();
            return (base_id != '0) ? base_id : ID_ONE;
        endfunction

        function int unsigned cap_limit();
            return (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
        endfunction

        function int find_slot(logic [ID_W-1:0] key);
            for (int i = 0; i < count; i++)
                if (ids[i] == key)
                    return i;
            return -1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BASE_ID)
                base_id = data[ID_W-1:0];
            else
                capacity = data[CAP_W-1:0];
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] key,
                                   logic [PL_W-1:0] pl, logic [SLOT_W-1:0] slot_idx);
            table_result_t r;
            int slot;
            r.status = ST_OK;
            r.id = '0;
            r.payload = '0;
            case (mode)
                MODE_ADD_AUTO:
                begin
                    if (count >= cap_limit())
                        r.status = ST_FULL;
                    else if (next_id == '0 || next_id == ID_ALL_ONES)
                        r.status = ST_EXHAUSTED;
                    else
                    begin
                        ids[count] = next_id;
                        pls[count] = pl;
                        count++;
                        r.id = next_id;
                        r.payload = pl;
                        next_id = next_id + ID_ONE;
                    end
                end
                MODE_ADD_ID:
                begin
                    if (count >= cap_limit())
                        r.status = ST_FULL;
                    else if (key == '0 || key == ID_ALL_ONES)
                        r.status = ST_INVALID;
                    else if (find_slot(key) >= 0)
                        r.status = ST_DUPLICATE;
                    else
                    begin
                        ids[count] = key;
                        pls[count] = pl;
                        count++;
                        // a given id pushes the issue counter past itself
                        if (key >= next_id)
                            next_id = key + ID_ONE;
                        r.id = key;
                        r.payload = pl;
                    end
                end
                MODE_GET_ID:
                begin
                    slot = find_slot(key);
                    if (slot >= 0)
                    begin
                        r.id = ids[slot];
                        r.payload = pls[slot];
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
                MODE_GET_IDX:
                begin
                    if (slot_idx < count)
                    begin
                        r.id = ids[slot_idx];
                        r.payload = pls[slot_idx];
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
                MODE_CLEAR:
                begin
                    count = 0;
                    next_id = start_id();
                end
                default:
                    ;
            endcase
            status_seen[int'(r.status)]++;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                                   logic [PL_W-1:0] pl);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: status %0d id %h payload %h",
                         $time, st, id, pl);
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (st !== want.status)
            begin
                errors++;
                $display("%0t status mismatch: expected %0d (%s) actual %0d",
                         $time, want.status, want.status.name(), st);
            end
            if (id !== want.id)
            begin
                errors++;
                $display("%0t result_id mismatch: expected %h actual %h", $time, want.id, id);
            end
            if (pl !== want.payload)
            begin
                errors++;
                $display("%0t result_payload mismatch: expected %h actual %h",
                         $time, want.payload, pl);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ikht_req_if req_ch ();
    ikht_rsp_if rsp_ch ();

    registry_mirror book;
    int quiet_cycles;
    int ready_style;
    int ready_hold;
    int ready_tick;
    int phases_run;

    id_keyed_handle_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // response side stall pattern, chosen per phase
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (ready_style)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= ((ready_tick % 7) >= 3);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        ready_hold = $urandom_range(10, 25);
                        rsp_ch.ready <= 1'b0;
                    end
                    else
                        rsp_ch.ready <= 1'b1;
                end
            endcase
        end
        ready_tick++;
    end

    // beat monitor: checks results, predicts accepted requests, watchdog
    always @(posedge clk)
    begin : beat_monitor
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                book.check_result(rsp_ch.status, rsp_ch.result_id, rsp_ch.result_payload);
                moved = 1'b1;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                book.note_request(req_ch.mode, req_ch.key_id, req_ch.payload_in,
                                  req_ch.slot_index);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, book.pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] key,
                            input logic [PL_W-1:0] pl, input logic [SLOT_W-1:0] slot_idx);
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.key_id     <= key;
        req_ch.payload_in <= pl;
        req_ch.slot_index <= slot_idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_req(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // wait until every result is back, then let the executor settle
    task automatic drain();
        idle_req(1);
        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 4)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        book.write_reg(idx, data);
    endtask

    // key biased toward stored ids, the issue counter and the invalid values
    function automatic logic [ID_W-1:0] pick_key(input int hit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hit_pct && book.count > 0)
            return book.ids[$urandom_range(0, book.count - 1)];
        r = $urandom_range(0, 99);
        if (r < 25)
            return book.next_id + ID_W'($urandom_range(0, 3));
        if (r < 40)
            return ID_W'($urandom_range(1, 20));
        if (r < 50)
            return '0;
        if (r < 60)
            return ID_ALL_ONES;
        if (r < 68)
            return ID_ALL_ONES - ID_W'($urandom_range(1, 3));
        return $urandom;
    endfunction

    task automatic random_request();
        int r;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   key;
        logic [PL_W-1:0]   pl;
        logic [SLOT_W-1:0] slot_idx;
        r = $urandom_range(0, 99);
        if (r < 28)
            mode = MODE_ADD_AUTO;
        else if (r < 48)
            mode = MODE_ADD_ID;
        else if (r < 72)
            mode = MODE_GET_ID;
        else if (r < 89)
            mode = MODE_GET_IDX;
        else if (r < 93)
            mode = MODE_CLEAR;
        else
            mode = MODE_W'(MODE_CLEAR + $urandom_range(1, 3));
        key = pick_key(mode == MODE_GET_ID ? 60 : 30);
        r = $urandom_range(0, 19);
        pl = (r == 0) ? '0 : (r == 1) ? '1 : PL_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            slot_idx = SLOT_W'($urandom_range(0, (book.count < TABLE_DEPTH) ?
                                                  book.count : TABLE_DEPTH - 1));
        else
            slot_idx = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
        send_req(mode, key, pl, slot_idx);
    endtask

    task automatic run_phase(input logic [ID_W-1:0] first, input logic [CAP_W-1:0] cap,
                             input int style, input bit bursty);
        int burst;
        drain();
        write_cfg(REG_BASE_ID, CFG_DATA_W'(first));
        write_cfg(REG_CAPACITY, CFG_DATA_W'(cap));
        ready_style = style;
        phases_run++;
        burst = 0;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            // sender bursts with random gaps in between
            if (bursty && burst == 0)
            begin
                burst = $urandom_range(1, 24);
                idle_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
            random_request();
            if (burst > 0)
                burst--;
        end
    endtask

    // stimulus and final verdict
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ADD_AUTO;
        req_ch.key_id = '0;
        req_ch.payload_in = '0;
        req_ch.slot_index = '0;
        rsp_ch.ready = 1'b0;
        ready_style = 0;
        ready_hold = 0;
        ready_tick = 0;
        quiet_cycles = 0;
        phases_run = 0;
        book = new();
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes of ids, invalid and duplicate ids, exhaustion
        send_req(MODE_GET_IDX, '0, '0, '0);
        send_req(MODE_GET_ID, ID_ONE, '0, '0);
        send_req(MODE_ADD_AUTO, '0, '0, '0);
        send_req(MODE_ADD_AUTO, '1, '1, '1);
        send_req(MODE_ADD_ID, '0, 32'h1234_5678, '0);
        send_req(MODE_ADD_ID, ID_ALL_ONES, 32'h1234_5678, '0);
        send_req(MODE_ADD_ID, ID_W'(2), 32'h1234_5678, '0);
        send_req(MODE_ADD_ID, ID_ALL_ONES - ID_ONE, 32'hA5A5_5A5A, '0);
        send_req(MODE_ADD_AUTO, '0, 32'hDEAD_BEEF, '0);
        send_req(MODE_GET_ID, ID_ALL_ONES - ID_ONE, '0, '0);
        send_req(MODE_GET_ID, '0, '0, '0);
        send_req(MODE_GET_ID, ID_ALL_ONES, '0, '0);
        send_req(MODE_GET_IDX, '0, '0, SLOT_W'(2));
        send_req(MODE_GET_IDX, '0, '0, '1);
        // undefined modes answer ok with zero fields
        for (int m = 1; m <= 3; m++)
            send_req(MODE_W'(MODE_CLEAR + m), '1, '1, '1);
        send_req(MODE_CLEAR, '0, '0, '0);
        send_req(MODE_GET_IDX, '0, '0, '0);

        // small capacity, base id of zero, full checked ahead of invalid id
        drain();
        write_cfg(REG_BASE_ID, '0);
        write_cfg(REG_CAPACITY, CFG_DATA_W'(2));
        send_req(MODE_CLEAR, '0, '0, '0);
        send_req(MODE_ADD_AUTO, '0, 32'h0000_0011, '0);
        send_req(MODE_ADD_ID, ID_W'(100), 32'h0000_0022, '0);
        send_req(MODE_ADD_AUTO, '0, 32'h0000_0033, '0);
        send_req(MODE_ADD_ID, '0, 32'h0000_0044, '0);
        send_req(MODE_GET_IDX, '0, '0, SLOT_W'(1));

        // random phases, capacity often changed without a clear
        run_phase(ID_ONE, CAP_W'(1), 0, 1'b0);
        run_phase(ID_ONE, CAP_W'(16), 1, 1'b1);
        run_phase('0, CAP_W'(31), 2, 1'b1);
        run_phase(ID_ALL_ONES, CAP_W'(16), 3, 1'b1);
        run_phase(ID_ALL_ONES - ID_W'(15), CAP_W'(5), 1, 1'b1);
        run_phase(ID_W'($urandom), CAP_W'(20), 0, 1'b0);
        run_phase(ID_ALL_ONES - ID_ONE, CAP_W'(0), 2, 1'b1);
        run_phase(ID_ONE, CAP_W'(8), 3, 1'b1);
        run_phase(ID_W'($urandom), CAP_W'(16), 1, 1'b1);
        run_phase('0, CAP_W'(3), 0, 1'b1);
        ready_style = 0;
        drain();

        $display("checked %0d results over %0d register settings", book.results_checked,
                 phases_run + 2);
        $display("statuses: ok %0d full %0d exhausted %0d invalid %0d duplicate %0d none %0d",
                 book.status_seen[0], book.status_seen[1], book.status_seen[2],
                 book.status_seen[3], book.status_seen[4], book.status_seen[5]);
        if (book.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
